// ===== rtl/core/nmsa_pkg.sv =====
// Package for the nearest marked slot allocator.
// Holds opcodes, controller-to-datapath command codes and the shared structs.
// No dependencies.
package nmsa_pkg;

    localparam int NMSA_SLOTS = 1024;
    localparam int POS_W      = 10;
    localparam int WORD_W     = 64;
    localparam int IDX_W      = 6;

    // Item opcodes.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Datapath commands issued by the controller.
    localparam logic [3:0] CMD_NONE    = 4'd0;
    localparam logic [3:0] CMD_LOAD    = 4'd1;
    localparam logic [3:0] CMD_CLR_WR  = 4'd2;
    localparam logic [3:0] CMD_RD      = 4'd3;
    localparam logic [3:0] CMD_MK_WR   = 4'd4;
    localparam logic [3:0] CMD_UP_EV   = 4'd5;
    localparam logic [3:0] CMD_DN_INIT = 4'd6;
    localparam logic [3:0] CMD_DN_EV   = 4'd7;
    localparam logic [3:0] CMD_PICK    = 4'd8;
    localparam logic [3:0] CMD_PK_WR   = 4'd9;
    localparam logic [3:0] CMD_CLR_GO  = 4'd10;
    localparam logic [3:0] CMD_QLOAD   = 4'd11;

    typedef struct packed {
        logic [3:0] op;
    } nmsa_cmd_t;

    typedef struct packed {
        logic addr_last;   // word address is the top word of the map
        logic addr_zero;   // word address is word zero
        logic mark_end;    // word address holds the top of the mark range
        logic mark_empty;  // mark range covers no slot
        logic up_none;     // request lies at or above the map, no upward search
        logic dn_none;     // request is zero, no downward search
        logic up_hit;      // current word has a slot at or above the request
        logic dn_hit;      // current word has a slot below the request
        logic found;       // a candidate was seen in either direction
    } nmsa_stat_t;

    function automatic logic [IDX_W-1:0] low_idx(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] iso;
        logic [IDX_W-1:0]  idx;
        iso = w & (~w + {{(WORD_W-1){1'b0}}, 1'b1});
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (iso[i])
            begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [IDX_W-1:0] high_idx(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] rev;
        for (int i = 0; i < WORD_W; i++) begin
            rev[i] = w[WORD_W-1-i];
        end
        return IDX_W'(WORD_W - 1) - low_idx(rev);
    endfunction

endpackage

// ===== rtl/core/nearest_marked_slot_allocator.sv =====
// Top level of the nearest marked slot allocator.
// Depends on nmsa_pkg, nmsa_ctrl and nmsa_dp.

// The block keeps a bitmap of SLOTS available slots in a memory of 64-bit words and takes
// one item at a time: an item is accepted on a clock edge where start is high and busy is
// low. A clear item and reset both sweep the map to zero, one word per cycle, so busy stays
// high after reset and after each clear until the sweep has written the last word. A mark
// item does a read and a write per word it touches. A query reads one word at a time,
// first upward from the request word until a slot turns up or the map ends, then downward
// from the word that holds the slot just below the request, then, if a slot was found,
// reads and rewrites its word to consume it. The two scans together touch at most
// (SLOTS+63)/64 + 1 words. The memory has a single registered read port. A query always
// answers with one result: done is high for exactly one cycle with found and assigned_pos,
// and the receiver cannot hold it off, so it must take the result in that cycle. Clear and
// mark items give no result.
module nearest_marked_slot_allocator
    import nmsa_pkg::*;
#(
    parameter int SLOTS = NMSA_SLOTS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       opcode,
    input  logic [POS_W-1:0] range_low,
    input  logic [POS_W-1:0] range_high,
    input  logic [POS_W-1:0] request_pos,
    output logic             done,
    output logic [POS_W-1:0] assigned_pos,
    output logic             found
);

    nmsa_cmd_t  cmd;
    nmsa_stat_t stat;

    // The controller sequences the sweeps and scans; the datapath owns the map and the search.
    nmsa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    nmsa_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .range_low    (range_low),
        .range_high   (range_high),
        .request_pos  (request_pos),
        .stat         (stat),
        .done         (done),
        .assigned_pos (assigned_pos),
        .found        (found)
    );

endmodule

// ===== rtl/core/nmsa_ctrl.sv =====
// Controller state machine of the nearest marked slot allocator.
// Depends on nmsa_pkg; drives nmsa_dp through command and status structs.
module nmsa_ctrl
    import nmsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] opcode,
    input  nmsa_stat_t stat,
    output nmsa_cmd_t  cmd,
    output logic       busy
);

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_MK_RD   = 4'd2;
    localparam logic [3:0] S_MK_WR   = 4'd3;
    localparam logic [3:0] S_UP_RD   = 4'd4;
    localparam logic [3:0] S_UP_EV   = 4'd5;
    localparam logic [3:0] S_DN_INIT = 4'd6;
    localparam logic [3:0] S_DN_RD   = 4'd7;
    localparam logic [3:0] S_DN_EV   = 4'd8;
    localparam logic [3:0] S_PICK    = 4'd9;
    localparam logic [3:0] S_PK_RD   = 4'd10;
    localparam logic [3:0] S_PK_WR   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = CMD_NONE;
        case (state_reg)
            S_CLR:
            begin
                cmd.op = CMD_CLR_WR;
                if (stat.addr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        OP_CLEAR:
                        begin
                            cmd.op     = CMD_CLR_GO;
                            state_next = S_CLR;
                        end
                        OP_MARK:
                        begin
                            cmd.op     = CMD_LOAD;
                            state_next = S_MK_RD;
                        end
                        OP_QUERY:
                        begin
                            cmd.op     = CMD_QLOAD;
                            state_next = S_UP_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MK_RD:
            begin
                if (stat.mark_empty)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = CMD_RD;
                    state_next = S_MK_WR;
                end
            end
            S_MK_WR:
            begin
                cmd.op     = CMD_MK_WR;
                state_next = stat.mark_end ? S_IDLE : S_MK_RD;
            end
            S_UP_RD:
            begin
                if (stat.up_none)
                begin
                    state_next = S_DN_INIT;
                end
                else
                begin
                    cmd.op     = CMD_RD;
                    state_next = S_UP_EV;
                end
            end
            S_UP_EV:
            begin
                cmd.op     = CMD_UP_EV;
                state_next = (stat.up_hit || stat.addr_last) ? S_DN_INIT : S_UP_RD;
            end
            S_DN_INIT:
            begin
                if (stat.dn_none)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    cmd.op     = CMD_DN_INIT;
                    state_next = S_DN_RD;
                end
            end
            S_DN_RD:
            begin
                cmd.op     = CMD_RD;
                state_next = S_DN_EV;
            end
            S_DN_EV:
            begin
                cmd.op     = CMD_DN_EV;
                state_next = (stat.dn_hit || stat.addr_zero) ? S_PICK : S_DN_RD;
            end
            S_PICK:
            begin
                cmd.op     = CMD_PICK;
                state_next = stat.found ? S_PK_RD : S_IDLE;
            end
            S_PK_RD:
            begin
                cmd.op     = CMD_RD;
                state_next = S_PK_WR;
            end
            S_PK_WR:
            begin
                cmd.op     = CMD_PK_WR;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/core/nmsa_dp.sv =====
// Datapath of the nearest marked slot allocator: slot map memory, scan
// address, range masks, bit search and result registers. Depends on nmsa_pkg.
module nmsa_dp
    import nmsa_pkg::*;
#(
    parameter int SLOTS = NMSA_SLOTS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  nmsa_cmd_t        cmd,
    input  logic [POS_W-1:0] range_low,
    input  logic [POS_W-1:0] range_high,
    input  logic [POS_W-1:0] request_pos,
    output nmsa_stat_t       stat,
    output logic             done,
    output logic [POS_W-1:0] assigned_pos,
    output logic             found
);

    localparam int MAP_WORDS = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int XW = ($clog2(SLOTS) + 1 > POS_W + 1) ? $clog2(SLOTS) + 1 : POS_W + 1;
    localparam logic [XW-1:0] SLOTS_X    = XW'(SLOTS);
    localparam logic [XW-1:0] TOP_SLOT_X = XW'(SLOTS - 1);
    localparam logic [AW-1:0] LAST_WORD  = AW'(MAP_WORDS - 1);

    logic [WORD_W-1:0] mem [MAP_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    logic [XW-1:0] lo_reg,     lo_next;
    logic [XW-1:0] hi_reg,     hi_next;
    logic [XW-1:0] req_reg,    req_next;
    logic [XW-1:0] up_pos_reg, up_pos_next;
    logic [XW-1:0] dn_pos_reg, dn_pos_next;
    logic [XW-1:0] pick_reg,   pick_next;
    logic [AW-1:0] addr_reg,   addr_next;
    logic          have_up_reg, have_up_next;
    logic          have_dn_reg, have_dn_next;
    logic          done_reg,   done_next;
    logic          found_reg,  found_next;
    logic [POS_W-1:0] assigned_reg, assigned_next;

    logic              rd_en;
    logic              wr_en;
    logic [WORD_W-1:0] wdata;

    logic [XW-1:0]     lo_in, hix_in, hi_in;
    logic [XW-1:0]     addr_x;
    logic [XW-1:0]     dn_start;
    logic [WORD_W-1:0] mark_mask;
    logic [WORD_W-1:0] up_word, dn_word;
    logic [IDX_W-1:0]  up_idx, dn_idx;
    logic [XW-1:0]     dist_dn, dist_up;
    logic              pick_dn;

    assign lo_in  = XW'(range_low);
    assign hix_in = XW'(range_high);
    assign hi_in  = (hix_in > TOP_SLOT_X) ? TOP_SLOT_X : hix_in;
    assign addr_x = XW'(addr_reg);

    // Top slot strictly below the request; a request beyond the map starts at the top slot.
    assign dn_start = ((req_reg < SLOTS_X) ? req_reg : SLOTS_X) - XW'(1);

    always_comb
    begin
        mark_mask = '1;
        if (addr_x == (lo_reg >> IDX_W))
        begin
            mark_mask = mark_mask & ({WORD_W{1'b1}} << lo_reg[IDX_W-1:0]);
        end
        if (addr_x == (hi_reg >> IDX_W))
        begin
            mark_mask = mark_mask & ({WORD_W{1'b1}} >> (IDX_W'(WORD_W - 1) - hi_reg[IDX_W-1:0]));
        end
    end

    always_comb
    begin
        up_word = rdata_reg;
        if (addr_x == (req_reg >> IDX_W))
        begin
            up_word = up_word & ({WORD_W{1'b1}} << req_reg[IDX_W-1:0]);
        end
        dn_word = rdata_reg;
        if (addr_x == (dn_start >> IDX_W))
        begin
            dn_word = dn_word & ({WORD_W{1'b1}} >> (IDX_W'(WORD_W - 1) - dn_start[IDX_W-1:0]));
        end
    end

    assign up_idx  = low_idx(up_word);
    assign dn_idx  = high_idx(dn_word);
    assign dist_dn = req_reg - dn_pos_reg;
    assign dist_up = up_pos_reg - req_reg;
    assign pick_dn = have_dn_reg && (!have_up_reg || (dist_dn <= dist_up));

    assign stat.addr_last  = (addr_reg == LAST_WORD);
    assign stat.addr_zero  = (addr_reg == '0);
    assign stat.mark_end   = (addr_x == (hi_reg >> IDX_W));
    assign stat.mark_empty = (lo_reg > hi_reg);
    assign stat.up_none    = (req_reg >= SLOTS_X);
    assign stat.dn_none    = (req_reg == '0);
    assign stat.up_hit     = |up_word;
    assign stat.dn_hit     = |dn_word;
    assign stat.found      = have_up_reg | have_dn_reg;

    always_comb
    begin
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        req_next      = req_reg;
        up_pos_next   = up_pos_reg;
        dn_pos_next   = dn_pos_reg;
        pick_next     = pick_reg;
        addr_next     = addr_reg;
        have_up_next  = have_up_reg;
        have_dn_next  = have_dn_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        assigned_next = assigned_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wdata         = '0;
        case (cmd.op)
            CMD_CLR_GO:
            begin
                addr_next = '0;
            end
            CMD_CLR_WR:
            begin
                wr_en     = 1'b1;
                wdata     = '0;
                addr_next = addr_reg + AW'(1);
            end
            CMD_LOAD,
            CMD_QLOAD:
            begin
                lo_next      = lo_in;
                hi_next      = hi_in;
                req_next     = XW'(request_pos);
                have_up_next = 1'b0;
                have_dn_next = 1'b0;
                // A mark starts at the word of its low end, a query at the word of its request.
                if (cmd.op == CMD_QLOAD)
                begin
                    addr_next = AW'(request_pos >> IDX_W);
                end
                else
                begin
                    addr_next = AW'(lo_in >> IDX_W);
                end
            end
            CMD_RD:
            begin
                rd_en = 1'b1;
            end
            CMD_MK_WR:
            begin
                wr_en     = 1'b1;
                wdata     = rdata_reg | mark_mask;
                addr_next = addr_reg + AW'(1);
            end
            CMD_UP_EV:
            begin
                if (|up_word)
                begin
                    have_up_next = 1'b1;
                    up_pos_next  = XW'({addr_reg, up_idx});
                end
                addr_next = addr_reg + AW'(1);
            end
            CMD_DN_INIT:
            begin
                addr_next = AW'(dn_start >> IDX_W);
            end
            CMD_DN_EV:
            begin
                if (|dn_word)
                begin
                    have_dn_next = 1'b1;
                    dn_pos_next  = XW'({addr_reg, dn_idx});
                end
                addr_next = addr_reg - AW'(1);
            end
            CMD_PICK:
            begin
                pick_next = pick_dn ? dn_pos_reg : up_pos_reg;
                addr_next = pick_dn ? AW'(dn_pos_reg >> IDX_W) : AW'(up_pos_reg >> IDX_W);
                if (!(have_up_reg || have_dn_reg))
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b0;
                    assigned_next = '0;
                end
            end
            CMD_PK_WR:
            begin
                wr_en         = 1'b1;
                wdata         = rdata_reg & ~({{(WORD_W-1){1'b0}}, 1'b1} << pick_reg[IDX_W-1:0]);
                done_next     = 1'b1;
                found_next    = 1'b1;
                assigned_next = pick_reg[POS_W-1:0];
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg    <= '0;
            have_up_reg <= 1'b0;
            have_dn_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            addr_reg    <= addr_next;
            have_up_reg <= have_up_next;
            have_dn_reg <= have_dn_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        req_reg      <= req_next;
        up_pos_reg   <= up_pos_next;
        dn_pos_reg   <= dn_pos_next;
        pick_reg     <= pick_next;
        found_reg    <= found_next;
        assigned_reg <= assigned_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr_reg] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    assign done         = done_reg;
    assign found        = found_reg;
    assign assigned_pos = assigned_reg;

endmodule
